/* hdl/atapts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO task-file sequencer package
// Shared widths, register indexes, task-file codes and the descriptor type
// that passes from the classifying front end to the port-write back end.
// ----------------------------------------------------------------------------
package atapts_pkg;

  // Field widths.
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned LBA_W     = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SECT_W    = 6;
  localparam int unsigned HEAD_W    = 4;

  // Default drive geometry for CHS translation.
  localparam int unsigned SECTORS_PER_TRACK_DEF  = 63;
  localparam int unsigned HEADS_PER_CYLINDER_DEF = 16;

  // Descriptor queue depth; a power of two.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRI_CMD_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRI_CTRL_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_CMD_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_CTRL_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LBA_MASK      = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [PORT_W-1:0] PRI_CMD_BASE_RST  = 16'h01F0;
  localparam logic [PORT_W-1:0] PRI_CTRL_BASE_RST = 16'h03F4;
  localparam logic [PORT_W-1:0] SEC_CMD_BASE_RST  = 16'h0170;
  localparam logic [PORT_W-1:0] SEC_CTRL_BASE_RST = 16'h0374;
  localparam logic [MASK_W-1:0] LBA_MASK_RST      = 4'h0;

  // Register offsets within the command and control blocks.
  localparam logic [2:0] OFS_DEV_CTRL = 3'd2;
  localparam logic [2:0] OFS_COUNT    = 3'd2;
  localparam logic [2:0] OFS_LBA0     = 3'd3;
  localparam logic [2:0] OFS_LBA1     = 3'd4;
  localparam logic [2:0] OFS_LBA2     = 3'd5;
  localparam logic [2:0] OFS_SELECT   = 3'd6;
  localparam logic [2:0] OFS_COMMAND  = 3'd7;

  // Task-file byte codes.
  localparam logic [7:0] DEV_CTRL_NIEN = 8'h02;
  localparam logic [7:0] DEV_CTRL_HOB  = 8'h82;
  localparam logic [7:0] SEL_LBA       = 8'hE0;
  localparam logic [7:0] SEL_CHS       = 8'hA0;
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

  // Configuration register set.
  typedef struct packed {
    logic [PORT_W-1:0] pri_cmd_base;
    logic [PORT_W-1:0] pri_ctrl_base;
    logic [PORT_W-1:0] sec_cmd_base;
    logic [PORT_W-1:0] sec_ctrl_base;
    logic [MASK_W-1:0] lba_mask;
  } cfg_t;

  // One classified request, ready to be written out.
  typedef struct packed {
    logic              ext;
    logic [PORT_W-1:0] cmd_base;
    logic [PORT_W-1:0] ctrl_base;
    logic [7:0]        select;
    logic [7:0]        count;
    logic [7:0]        lba0;
    logic [7:0]        lba1;
    logic [7:0]        lba2;
    logic [7:0]        lba3;
    logic [7:0]        command;
  } task_t;

endpackage

/* hdl/atapts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO task-file sequencer front end
// Three-stage pipeline that classifies each request (LBA48, LBA28 or CHS),
// translates the address to CHS by constant reciprocal multiplication and
// builds the task-file descriptor. One request may enter every cycle.
// ----------------------------------------------------------------------------
module atapts_front import atapts_pkg::*; #(
  parameter int unsigned SECTORS_PER_TRACK  = SECTORS_PER_TRACK_DEF,
  parameter int unsigned HEADS_PER_CYLINDER = HEADS_PER_CYLINDER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               bus_channel_i,
  input  logic               unit_i,
  input  logic               is_write_i,
  input  logic [LBA_W-1:0]   block_address_i,
  input  logic [COUNT_W-1:0] sector_count_i,
  input  cfg_t               cfg_i,
  output logic               push_o,
  output task_t              task_o
);

  // Exact division of any value below 2^28 by a constant d: multiply by
  // ceil(2^(28+ceil(log2 d)) / d) and shift.
  localparam int unsigned LoW      = 28;
  localparam int unsigned MulW     = LoW + 1;
  localparam int unsigned ProdW    = LoW + MulW;
  localparam int unsigned SptShift = LoW + $clog2(SECTORS_PER_TRACK);
  localparam int unsigned HpcShift = LoW + $clog2(HEADS_PER_CYLINDER);
  localparam logic [63:0] SptMulFull =
    ((64'd1 << SptShift) + 64'(SECTORS_PER_TRACK) - 64'd1) / 64'(SECTORS_PER_TRACK);
  localparam logic [63:0] HpcMulFull =
    ((64'd1 << HpcShift) + 64'(HEADS_PER_CYLINDER) - 64'd1) / 64'(HEADS_PER_CYLINDER);
  localparam logic [MulW-1:0] SptMul = SptMulFull[MulW-1:0];
  localparam logic [MulW-1:0] HpcMul = HpcMulFull[MulW-1:0];
  localparam logic [LoW-1:0]  SptVal = LoW'(SECTORS_PER_TRACK);
  localparam logic [LoW-1:0]  HpcVal = LoW'(HEADS_PER_CYLINDER);

  // Stage A: capture request, classify, start the sector division.
  logic              a_valid_q;
  logic              a_ext_q, a_cap_q, a_unit_q, a_wr_q;
  logic [LBA_W-1:0]  a_lba_q;
  logic [7:0]        a_count_q;
  logic [PORT_W-1:0] a_cmd_base_q, a_ctrl_base_q;
  logic [ProdW-1:0]  a_prod_q;

  logic              a_ext_d, a_cap_d;
  logic [7:0]        a_count_d;
  logic [PORT_W-1:0] a_cmd_base_d, a_ctrl_base_d;
  logic [ProdW-1:0]  a_prod_d;

  always_comb begin
    a_ext_d       = |block_address_i[LBA_W-1:LoW];
    a_cap_d       = cfg_i.lba_mask[{bus_channel_i, unit_i}];
    a_count_d     = (|sector_count_i[COUNT_W-1:8]) ? 8'h00 : sector_count_i[7:0];
    a_cmd_base_d  = bus_channel_i ? cfg_i.sec_cmd_base : cfg_i.pri_cmd_base;
    a_ctrl_base_d = bus_channel_i ? cfg_i.sec_ctrl_base : cfg_i.pri_ctrl_base;
    a_prod_d      = ProdW'(block_address_i[LoW-1:0]) * ProdW'(SptMul);
  end

  // Stage B: sector number and start of the head/cylinder division.
  logic              b_valid_q;
  logic              b_ext_q, b_cap_q, b_unit_q, b_wr_q;
  logic [LBA_W-1:0]  b_lba_q;
  logic [7:0]        b_count_q;
  logic [PORT_W-1:0] b_cmd_base_q, b_ctrl_base_q;
  logic [LoW-1:0]    b_quot_q;
  logic [SECT_W-1:0] b_sect_q;
  logic [ProdW-1:0]  b_prod_q;

  logic [ProdW-1:0]  quot_wide;
  logic [LoW-1:0]    quot_d;
  logic [LoW-1:0]    rem_full;
  logic [SECT_W-1:0] sect_d;
  logic [ProdW-1:0]  b_prod_d;

  always_comb begin
    quot_wide = a_prod_q >> SptShift;
    quot_d    = quot_wide[LoW-1:0];
    rem_full  = a_lba_q[LoW-1:0] - quot_d * SptVal;
    sect_d    = rem_full[SECT_W-1:0] + SECT_W'(1);
    b_prod_d  = ProdW'(quot_d) * ProdW'(HpcMul);
  end

  // Valid bits of the two pipeline registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept_i;
      b_valid_q <= a_valid_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    a_ext_q       <= a_ext_d;
    a_cap_q       <= a_cap_d;
    a_unit_q      <= unit_i;
    a_wr_q        <= is_write_i;
    a_lba_q       <= block_address_i;
    a_count_q     <= a_count_d;
    a_cmd_base_q  <= a_cmd_base_d;
    a_ctrl_base_q <= a_ctrl_base_d;
    a_prod_q      <= a_prod_d;

    b_ext_q       <= a_ext_q;
    b_cap_q       <= a_cap_q;
    b_unit_q      <= a_unit_q;
    b_wr_q        <= a_wr_q;
    b_lba_q       <= a_lba_q;
    b_count_q     <= a_count_q;
    b_cmd_base_q  <= a_cmd_base_q;
    b_ctrl_base_q <= a_ctrl_base_q;
    b_quot_q      <= quot_d;
    b_sect_q      <= sect_d;
    b_prod_q      <= b_prod_d;
  end

  // Stage C: cylinder and head, then assemble the descriptor.
  logic [ProdW-1:0]  cyl_wide;
  logic [LoW-1:0]    cyl;
  logic [LoW-1:0]    head_full;
  logic [HEAD_W-1:0] head;

  always_comb begin
    cyl_wide  = b_prod_q >> HpcShift;
    cyl       = cyl_wide[LoW-1:0];
    head_full = b_quot_q - cyl * HpcVal;
    head      = head_full[HEAD_W-1:0];

    task_o           = '0;
    task_o.ext       = b_ext_q;
    task_o.cmd_base  = b_cmd_base_q;
    task_o.ctrl_base = b_ctrl_base_q;
    task_o.count     = b_count_q;
    task_o.lba3      = b_lba_q[31:24];

    if (b_ext_q) begin
      task_o.select  = SEL_LBA | {3'b000, b_unit_q, 4'h0};
      task_o.lba0    = b_lba_q[7:0];
      task_o.lba1    = b_lba_q[15:8];
      task_o.lba2    = b_lba_q[23:16];
      task_o.command = b_wr_q ? CMD_WRITE_EXT : CMD_READ_EXT;
    end else if (b_cap_q) begin
      task_o.select  = SEL_LBA | {3'b000, b_unit_q, b_lba_q[27:24]};
      task_o.lba0    = b_lba_q[7:0];
      task_o.lba1    = b_lba_q[15:8];
      task_o.lba2    = b_lba_q[23:16];
      task_o.command = b_wr_q ? CMD_WRITE : CMD_READ;
    end else begin
      task_o.select  = SEL_CHS | {3'b000, b_unit_q, head};
      task_o.lba0    = {2'b00, b_sect_q};
      task_o.lba1    = cyl[7:0];
      task_o.lba2    = cyl[15:8];
      task_o.command = b_wr_q ? CMD_WRITE : CMD_READ;
    end
  end

  assign push_o = b_valid_q;

endmodule

/* hdl/atapts_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO task-file sequencer descriptor queue
// Small FIFO between the front end and the port-write back end. The top
// level keeps it from overflowing by counting requests in flight.
// ----------------------------------------------------------------------------
module atapts_queue import atapts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t data_i,
  input  logic  pop_i,
  output logic  empty_o,
  output task_t data_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  task_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - CntW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign empty_o = (fill_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

/* hdl/atapts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO task-file sequencer back end
// Walks the write sequence of the descriptor at the head of the queue, one
// port write per cycle while one is queued, and goes straight on to the next.
// ----------------------------------------------------------------------------
module atapts_back import atapts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  task_t             task_i,
  output logic              pop_o,
  output logic              strobe_o,
  output logic [PORT_W-1:0] port_address_o,
  output logic [7:0]        write_data_o,
  output logic              last_write_o
);

  // Sequence steps; the HOB block is only taken for LBA48.
  localparam logic [4:0] STEP_NIEN      = 5'd0;
  localparam logic [4:0] STEP_SELECT    = 5'd1;
  localparam logic [4:0] STEP_HOB0_SET  = 5'd2;
  localparam logic [4:0] STEP_HOB0_WR   = 5'd3;
  localparam logic [4:0] STEP_HOB0_CLR  = 5'd4;
  localparam logic [4:0] STEP_HOB1_SET  = 5'd5;
  localparam logic [4:0] STEP_HOB1_WR   = 5'd6;
  localparam logic [4:0] STEP_HOB1_CLR  = 5'd7;
  localparam logic [4:0] STEP_HOB2_SET  = 5'd8;
  localparam logic [4:0] STEP_HOB2_WR   = 5'd9;
  localparam logic [4:0] STEP_HOB2_CLR  = 5'd10;
  localparam logic [4:0] STEP_HOB3_SET  = 5'd11;
  localparam logic [4:0] STEP_HOB3_WR   = 5'd12;
  localparam logic [4:0] STEP_HOB3_CLR  = 5'd13;
  localparam logic [4:0] STEP_COUNT     = 5'd14;
  localparam logic [4:0] STEP_LBA0      = 5'd15;
  localparam logic [4:0] STEP_LBA1      = 5'd16;
  localparam logic [4:0] STEP_LBA2      = 5'd17;
  localparam logic [4:0] STEP_CMD       = 5'd18;

  logic [4:0]        step_q, step_d;
  logic              strobe_q;
  logic [PORT_W-1:0] port_q, port_d;
  logic [7:0]        data_q, data_d;
  logic              last_q, last_d;
  logic              use_ctrl;
  logic [2:0]        ofs;

  // Port and data of the current step.
  always_comb begin
    use_ctrl = 1'b0;
    ofs      = OFS_COMMAND;
    data_d   = 8'h00;
    last_d   = 1'b0;
    case (step_q)
      STEP_NIEN: begin
        use_ctrl = 1'b1;
        ofs      = OFS_DEV_CTRL;
        data_d   = DEV_CTRL_NIEN;
      end
      STEP_SELECT: begin
        ofs    = OFS_SELECT;
        data_d = task_i.select;
      end
      STEP_HOB0_SET, STEP_HOB1_SET, STEP_HOB2_SET, STEP_HOB3_SET: begin
        use_ctrl = 1'b1;
        ofs      = OFS_DEV_CTRL;
        data_d   = DEV_CTRL_HOB;
      end
      STEP_HOB0_CLR, STEP_HOB1_CLR, STEP_HOB2_CLR, STEP_HOB3_CLR: begin
        use_ctrl = 1'b1;
        ofs      = OFS_DEV_CTRL;
        data_d   = DEV_CTRL_NIEN;
      end
      STEP_HOB0_WR: begin
        ofs = OFS_COUNT;
      end
      STEP_HOB1_WR: begin
        ofs    = OFS_LBA0;
        data_d = task_i.lba3;
      end
      STEP_HOB2_WR: begin
        ofs = OFS_LBA1;
      end
      STEP_HOB3_WR: begin
        ofs = OFS_LBA2;
      end
      STEP_COUNT: begin
        ofs    = OFS_COUNT;
        data_d = task_i.count;
      end
      STEP_LBA0: begin
        ofs    = OFS_LBA0;
        data_d = task_i.lba0;
      end
      STEP_LBA1: begin
        ofs    = OFS_LBA1;
        data_d = task_i.lba1;
      end
      STEP_LBA2: begin
        ofs    = OFS_LBA2;
        data_d = task_i.lba2;
      end
      STEP_CMD: begin
        ofs    = OFS_COMMAND;
        data_d = task_i.command;
        last_d = 1'b1;
      end
      default: begin
        ofs = OFS_COMMAND;
      end
    endcase
    port_d = (use_ctrl ? task_i.ctrl_base : task_i.cmd_base) + PORT_W'(ofs);
  end

  // Step sequencing; LBA28 and CHS skip the HOB block.
  always_comb begin
    step_d = step_q;
    pop_o  = 1'b0;
    if (!empty_i) begin
      if (step_q == STEP_CMD) begin
        step_d = STEP_NIEN;
        pop_o  = 1'b1;
      end else if (step_q == STEP_SELECT && !task_i.ext) begin
        step_d = STEP_COUNT;
      end else if (step_q > STEP_CMD) begin
        step_d = STEP_NIEN;
      end else begin
        step_d = step_q + 5'd1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_NIEN;
      strobe_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      strobe_q <= !empty_i;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    port_q <= port_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  assign strobe_o       = strobe_q;
  assign port_address_o = port_q;
  assign write_data_o   = data_q;
  assign last_write_o   = last_q;

endmodule

/* hdl/ata_pio_taskfile_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO task-file sequencer
// A request passes the stage A and B registers and the queue before the back
// end strobes its first port write. The back end issues one port write per
// cycle while a request is queued, and requests follow gapless.
// Reset: registers return to the standard primary and secondary port bases,
// no unit LBA-capable, and any queued requests are dropped.
// ----------------------------------------------------------------------------
module ata_pio_taskfile_sequencer import atapts_pkg::*; #(
  parameter int unsigned SECTORS_PER_TRACK  = SECTORS_PER_TRACK_DEF,
  parameter int unsigned HEADS_PER_CYLINDER = HEADS_PER_CYLINDER_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 bus_channel_i,
  input  logic                 unit_i,
  input  logic                 is_write_i,
  input  logic [LBA_W-1:0]     block_address_i,
  input  logic [COUNT_W-1:0]   sector_count_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PORT_W-1:0]    cfg_data_i,
  output logic                 out_strobe_o,
  output logic [PORT_W-1:0]    port_address_o,
  output logic [7:0]           write_data_o,
  output logic                 last_write_o
);

  localparam int unsigned OccW = $clog2(QUEUE_DEPTH + 1);

  cfg_t            cfg_q;
  logic [OccW-1:0] occ_q;
  logic            accept;
  logic            push;
  logic            pop;
  logic            empty;
  task_t           front_task;
  task_t           head_task;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pri_cmd_base  <= PRI_CMD_BASE_RST;
      cfg_q.pri_ctrl_base <= PRI_CTRL_BASE_RST;
      cfg_q.sec_cmd_base  <= SEC_CMD_BASE_RST;
      cfg_q.sec_ctrl_base <= SEC_CTRL_BASE_RST;
      cfg_q.lba_mask      <= LBA_MASK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PRI_CMD_BASE:  cfg_q.pri_cmd_base  <= cfg_data_i;
        REG_PRI_CTRL_BASE: cfg_q.pri_ctrl_base <= cfg_data_i;
        REG_SEC_CMD_BASE:  cfg_q.sec_cmd_base  <= cfg_data_i;
        REG_SEC_CTRL_BASE: cfg_q.sec_ctrl_base <= cfg_data_i;
        REG_LBA_MASK:      cfg_q.lba_mask      <= cfg_data_i[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Requests in the front pipeline or the queue; full means no new request.
  assign accept = start && !busy;
  assign busy   = (occ_q == OccW'(QUEUE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (accept && !pop) begin
      occ_q <= occ_q + OccW'(1);
    end else if (pop && !accept) begin
      occ_q <= occ_q - OccW'(1);
    end
  end

  atapts_front #(
    .SECTORS_PER_TRACK  (SECTORS_PER_TRACK),
    .HEADS_PER_CYLINDER (HEADS_PER_CYLINDER)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .bus_channel_i   (bus_channel_i),
    .unit_i          (unit_i),
    .is_write_i      (is_write_i),
    .block_address_i (block_address_i),
    .sector_count_i  (sector_count_i),
    .cfg_i           (cfg_q),
    .push_o          (push),
    .task_o          (front_task)
  );

  atapts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_task),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_task)
  );

  atapts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .task_i         (head_task),
    .pop_o          (pop),
    .strobe_o       (out_strobe_o),
    .port_address_o (port_address_o),
    .write_data_o   (write_data_o),
    .last_write_o   (last_write_o)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO task-file sequencer testbench
// Drives sector-access requests and configuration writes from a queue of
// pending actions, predicts the ordered port writes of every accepted request
// and checks each strobed port write against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import atapts_pkg::*;

  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_SETTLE = 8;
  localparam int unsigned TIMEOUT_NS   = 200_000;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_LBA_MASK + 3'd1;

  typedef enum logic [1:0] {ACT_REQUEST, ACT_CONFIG, ACT_DRAIN} action_e;
  typedef enum logic [1:0] {MODE_CHS, MODE_LBA28, MODE_LBA48} addr_mode_e;

  typedef struct {
    action_e              kind;
    logic                 bus_channel;
    logic                 unit;
    logic                 is_write;
    logic [LBA_W-1:0]     lba;
    logic [COUNT_W-1:0]   count;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PORT_W-1:0]    cfg_data;
    int unsigned          gap;
  } action_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [7:0]        data;
    logic              last;
  } port_write_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Request and configuration channels driven by the testbench.
  logic                 req_start   = 1'b0;
  logic                 req_channel = 1'b0;
  logic                 req_unit    = 1'b0;
  logic                 req_write   = 1'b0;
  logic [LBA_W-1:0]     req_lba     = '0;
  logic [COUNT_W-1:0]   req_count   = '0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [PORT_W-1:0]    cfg_data    = '0;

  logic                 dut_busy;
  logic                 cfg_ready_o;
  logic                 out_strobe_o;
  logic [PORT_W-1:0]    port_address_o;
  logic [7:0]           write_data_o;
  logic                 last_write_o;

  action_t      pending_actions[$];
  port_write_t  expected_writes[$];
  int unsigned  gap_max = 4;
  int unsigned  mismatch_count = 0;
  logic         results_pending = 1'b0;
  logic         stimulus_done = 1'b0;

  ata_pio_taskfile_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (req_start),
    .busy            (dut_busy),
    .bus_channel_i   (req_channel),
    .unit_i          (req_unit),
    .is_write_i      (req_write),
    .block_address_i (req_lba),
    .sector_count_i  (req_count),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .out_strobe_o    (out_strobe_o),
    .port_address_o  (port_address_o),
    .write_data_o    (write_data_o),
    .last_write_o    (last_write_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction of the port writes
  // ---------------------------------------------------------------------------

  function automatic void push_expected(input logic [PORT_W-1:0] port,
                                        input logic [7:0] data, input logic last);
    port_write_t w;
    w.port = port;
    w.data = data;
    w.last = last;
    expected_writes.push_back(w);
  endfunction

  // A high-order register write is wrapped by HOB set and clear.
  function automatic void push_hob_write(input logic [PORT_W-1:0] ctrl,
                                         input logic [PORT_W-1:0] port,
                                         input logic [7:0] data);
    push_expected(ctrl + OFS_DEV_CTRL, DEV_CTRL_HOB, 1'b0);
    push_expected(port, data, 1'b0);
    push_expected(ctrl + OFS_DEV_CTRL, DEV_CTRL_NIEN, 1'b0);
  endfunction

  function automatic void predict_taskfile_writes(input cfg_t cfg, input logic channel,
                                                  input logic unit, input logic is_write,
                                                  input logic [LBA_W-1:0] lba,
                                                  input logic [COUNT_W-1:0] count);
    logic [PORT_W-1:0] cb, kb;
    logic [7:0]        b0, b1, b2, b3, sel, cmd, count_byte;
    logic [3:0]        head;
    logic [31:0]       sect, base, cyl, track;
    addr_mode_e        mode;
    cb   = channel ? cfg.sec_cmd_base  : cfg.pri_cmd_base;
    kb   = channel ? cfg.sec_ctrl_base : cfg.pri_ctrl_base;
    b3   = 8'h00;
    head = 4'h0;
    if (lba >= 32'h1000_0000) begin
      mode = MODE_LBA48;
      b0 = lba[7:0];
      b1 = lba[15:8];
      b2 = lba[23:16];
      b3 = lba[31:24];
    end else if (cfg.lba_mask[{channel, unit}]) begin
      mode = MODE_LBA28;
      b0   = lba[7:0];
      b1   = lba[15:8];
      b2   = lba[23:16];
      head = lba[27:24];
    end else begin
      // CHS: sector numbers start at 1; only the low 16 cylinder bits survive.
      mode  = MODE_CHS;
      sect  = lba % SECTORS_PER_TRACK_DEF + 1;
      base  = lba - (sect - 1);
      cyl   = base / (HEADS_PER_CYLINDER_DEF * SECTORS_PER_TRACK_DEF);
      track = (base % (HEADS_PER_CYLINDER_DEF * SECTORS_PER_TRACK_DEF))
              / SECTORS_PER_TRACK_DEF;
      b0    = sect[7:0];
      b1    = cyl[7:0];
      b2    = cyl[15:8];
      head  = track[3:0];
    end
    sel = ((mode == MODE_CHS) ? SEL_CHS : SEL_LBA) | {3'b000, unit, head};
    if (mode == MODE_LBA48) cmd = is_write ? CMD_WRITE_EXT : CMD_READ_EXT;
    else cmd = is_write ? CMD_WRITE : CMD_READ;
    count_byte = (count > 16'd255) ? 8'h00 : count[7:0];

    push_expected(kb + OFS_DEV_CTRL, DEV_CTRL_NIEN, 1'b0);
    push_expected(cb + OFS_SELECT, sel, 1'b0);
    if (mode == MODE_LBA48) begin
      push_hob_write(kb, cb + OFS_COUNT, 8'h00);
      push_hob_write(kb, cb + OFS_LBA0, b3);
      push_hob_write(kb, cb + OFS_LBA1, 8'h00);
      push_hob_write(kb, cb + OFS_LBA2, 8'h00);
    end
    push_expected(cb + OFS_COUNT, count_byte, 1'b0);
    push_expected(cb + OFS_LBA0, b0, 1'b0);
    push_expected(cb + OFS_LBA1, b1, 1'b0);
    push_expected(cb + OFS_LBA2, b2, 1'b0);
    push_expected(cb + OFS_COMMAND, cmd, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic void add_request(input logic channel, input logic unit,
                                      input logic is_write, input logic [LBA_W-1:0] lba,
                                      input logic [COUNT_W-1:0] count);
    action_t a;
    a = '{kind: ACT_REQUEST, default: '0};
    a.bus_channel = channel;
    a.unit        = unit;
    a.is_write    = is_write;
    a.lba         = lba;
    a.count       = count;
    a.gap         = $urandom_range(0, gap_max);
    pending_actions.push_back(a);
  endfunction

  function automatic void add_config(input logic [CFG_IDX_W-1:0] index,
                                     input logic [PORT_W-1:0] data);
    action_t a;
    a = '{kind: ACT_CONFIG, default: '0};
    a.cfg_index = index;
    a.cfg_data  = data;
    pending_actions.push_back(a);
  endfunction

  // Holds the sender until every predicted port write has been seen.
  function automatic void add_drain();
    action_t a;
    a = '{kind: ACT_DRAIN, default: '0};
    pending_actions.push_back(a);
  endfunction

  function automatic logic [PORT_W-1:0] pick_base();
    logic [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return rnd[PORT_W-1:0];
    endcase
  endfunction

  function automatic void add_random_request();
    logic [31:0]        rnd;
    logic [LBA_W-1:0]   lba_pick;
    logic [COUNT_W-1:0] count_pick;
    rnd = $urandom;
    case ($urandom_range(0, 3))
      0:       lba_pick = rnd | 32'h1000_0000;
      1:       lba_pick = rnd & 32'h0FFF_FFFF;
      2:       lba_pick = $urandom_range(0, 4095);
      default: lba_pick = rnd;
    endcase
    rnd = $urandom;
    count_pick = $urandom_range(0, 1) ? {8'h00, rnd[7:0]} : rnd[15:0];
    add_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), lba_pick, count_pick);
  endfunction

  initial begin
    // Reset values, no unit LBA-capable: CHS corners, count limits, LBA48.
    add_request(1'b0, 1'b0, 1'b0, 32'h0000_0000, 16'd0);
    add_request(1'b0, 1'b1, 1'b1, 32'd62, 16'd255);
    add_request(1'b1, 1'b0, 1'b0, 32'd63, 16'd256);
    add_request(1'b1, 1'b1, 1'b1, 32'd1007, 16'hFFFF);
    add_request(1'b0, 1'b0, 1'b0, 32'd1008, 16'd1);
    add_request(1'b1, 1'b0, 1'b1, 32'h0FFF_FFFF, 16'd128);
    add_request(1'b0, 1'b1, 1'b0, 32'h1000_0000, 16'd300);
    add_request(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    add_request(1'b0, 1'b0, 1'b1, 32'h1234_5678, 16'd0);

    // Masked LBA bits with upper data bits set, and writes to unused indexes.
    add_drain();
    add_config(REG_LBA_MASK, 16'hFFF5);
    for (int i = 0; i < 3; i++) add_config(CFG_IDX_W'(REG_UNUSED_FIRST + i), 16'hFFFF);
    add_request(1'b0, 1'b0, 1'b0, 32'h0FFF_FFFF, 16'd255);
    add_request(1'b0, 1'b1, 1'b0, 32'h0FFF_FFFF, 16'd255);
    add_request(1'b1, 1'b0, 1'b1, 32'h0ABC_DEF1, 16'd256);
    add_request(1'b1, 1'b1, 1'b1, 32'h0000_0000, 16'd7);
    add_request(1'b1, 1'b0, 1'b0, 32'h1000_0000, 16'd9);

    // All bases at the top so every port address wraps.
    add_drain();
    add_config(REG_PRI_CMD_BASE, 16'hFFFF);
    add_config(REG_PRI_CTRL_BASE, 16'hFFFF);
    add_config(REG_SEC_CMD_BASE, 16'hFFFF);
    add_config(REG_SEC_CTRL_BASE, 16'hFFFF);
    add_config(REG_LBA_MASK, 16'h000A);
    add_request(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'd1);
    add_request(1'b0, 1'b1, 1'b1, 32'h0F0F_0F0F, 16'd2);
    add_request(1'b1, 1'b1, 1'b0, 32'h00AB_CDEF, 16'd3);
    add_request(1'b1, 1'b0, 1'b1, 32'h07FF_FFFF, 16'hFFFF);

    // All bases at zero, mask full.
    add_drain();
    add_config(REG_PRI_CMD_BASE, 16'h0000);
    add_config(REG_PRI_CTRL_BASE, 16'h0000);
    add_config(REG_SEC_CMD_BASE, 16'h0000);
    add_config(REG_SEC_CTRL_BASE, 16'h0000);
    add_config(REG_LBA_MASK, 16'h000F);
    add_request(1'b0, 1'b1, 1'b1, 32'h1000_0000, 16'd255);
    add_request(1'b1, 1'b0, 1'b0, 32'h0000_0001, 16'd256);

    // Random phases, each under a fresh register setting. Odd phases idle
    // between requests, even ones run back to back.
    for (int p = 0; p < 6; p++) begin
      add_drain();
      add_config(REG_PRI_CMD_BASE, pick_base());
      add_config(REG_PRI_CTRL_BASE, pick_base());
      add_config(REG_SEC_CMD_BASE, pick_base());
      add_config(REG_SEC_CTRL_BASE, pick_base());
      add_config(REG_LBA_MASK, pick_base());
      add_config(CFG_IDX_W'(REG_UNUSED_FIRST + $urandom_range(0, 2)), pick_base());
      gap_max = (p % 2) ? 4 : 0;
      for (int i = 0; i < 17; i++) begin
        if (i == 10 && (p % 3) == 1) add_drain();
        add_random_request();
      end
    end
    add_drain();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (!(stimulus_done && !results_pending)) @(posedge clk_i);
    repeat (DRAIN_SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: one pending action at a time, with gaps after requests
  // ---------------------------------------------------------------------------
  int unsigned gap_left    = 0;
  int unsigned settle_left = 0;
  int unsigned cur_gap     = 0;
  logic        draining    = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    action_t     act;
    logic        start_next, cfg_next, drain_now;
    int unsigned gap_now, settle_now;
    if (!rst_ni) begin
      req_start   <= 1'b0;
      cfg_valid   <= 1'b0;
      gap_left    <= 0;
      settle_left <= 0;
      draining    <= 1'b0;
    end else begin
      start_next = req_start && dut_busy;
      cfg_next   = cfg_valid && !cfg_ready_o;
      gap_now    = gap_left;
      settle_now = settle_left;
      drain_now  = draining;
      if (req_start && !dut_busy) gap_now = cur_gap;
      if (!start_next && !cfg_next) begin
        if (drain_now) begin
          // Nothing outstanding, then a settle countdown for the pipeline to empty.
          if (!results_pending) begin
            if (settle_now == 0) drain_now = 1'b0;
            else settle_now--;
          end
        end else if (gap_now != 0) begin
          gap_now--;
        end else if (pending_actions.size() != 0) begin
          act = pending_actions.pop_front();
          case (act.kind)
            ACT_REQUEST: begin
              start_next = 1'b1;
              req_channel <= act.bus_channel;
              req_unit    <= act.unit;
              req_write   <= act.is_write;
              req_lba     <= act.lba;
              req_count   <= act.count;
              cur_gap     <= act.gap;
            end
            ACT_CONFIG: begin
              cfg_next = 1'b1;
              cfg_index <= act.cfg_index;
              cfg_data  <= act.cfg_data;
            end
            default: begin
              drain_now  = 1'b1;
              settle_now = DRAIN_SETTLE;
            end
          endcase
        end else begin
          stimulus_done <= 1'b1;
        end
      end
      req_start   <= start_next;
      cfg_valid   <= cfg_next;
      gap_left    <= gap_now;
      settle_left <= settle_now;
      draining    <= drain_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: tracks registers, predicts on each accepted request and checks
  // every strobed port write
  // ---------------------------------------------------------------------------
  cfg_t cfg_model;

  always @(posedge clk_i or negedge rst_ni) begin : observe_proc
    port_write_t want;
    if (!rst_ni) begin
      cfg_model.pri_cmd_base  = PRI_CMD_BASE_RST;
      cfg_model.pri_ctrl_base = PRI_CTRL_BASE_RST;
      cfg_model.sec_cmd_base  = SEC_CMD_BASE_RST;
      cfg_model.sec_ctrl_base = SEC_CTRL_BASE_RST;
      cfg_model.lba_mask      = LBA_MASK_RST;
      results_pending <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          REG_PRI_CMD_BASE:  cfg_model.pri_cmd_base  = cfg_data;
          REG_PRI_CTRL_BASE: cfg_model.pri_ctrl_base = cfg_data;
          REG_SEC_CMD_BASE:  cfg_model.sec_cmd_base  = cfg_data;
          REG_SEC_CTRL_BASE: cfg_model.sec_ctrl_base = cfg_data;
          REG_LBA_MASK:      cfg_model.lba_mask      = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end

      if (req_start && !dut_busy) begin
        predict_taskfile_writes(cfg_model, req_channel, req_unit, req_write,
                                req_lba, req_count);
      end

      if (out_strobe_o) begin
        if (expected_writes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] port write with none expected: port %h data %h last %b",
                     $time, port_address_o, write_data_o, last_write_o);
        end else begin
          want = expected_writes.pop_front();
          if (port_address_o !== want.port || write_data_o !== want.data ||
              last_write_o !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"[%0t] port write mismatch: expected port %h data %h last %b,",
                        " got port %h data %h last %b"},
                       $time, want.port, want.data, want.last,
                       port_address_o, write_data_o, last_write_o);
          end
        end
      end

      results_pending <= (expected_writes.size() != 0);
    end
  end

endmodule

/* files.f */
hdl/atapts_pkg.sv
hdl/atapts_front.sv
hdl/atapts_queue.sv
hdl/atapts_back.sv
hdl/ata_pio_taskfile_sequencer.sv
bench/tb.sv
